/* hw/rtl/sird_pkg.sv */
// Shared constants and handshake types for the signed integer to radix digits block.
// No dependencies.
`default_nettype none

package sird_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int RADIX_WIDTH = 5;
  localparam int DIGIT_WIDTH = 4;
  // dividend bits consumed per divider cycle; VALUE_WIDTH must be a multiple of it
  localparam int STEP_BITS   = 8;
  localparam int DIV_STEPS   = VALUE_WIDTH / STEP_BITS;
  localparam int STEP_CNT_W  = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int NDIG_W      = $clog2(VALUE_WIDTH + 1);

  localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = RADIX_WIDTH'(10);
  localparam logic [RADIX_WIDTH-1:0] RADIX_MIN   = RADIX_WIDTH'(2);
  localparam logic [RADIX_WIDTH-1:0] RADIX_MAX   = RADIX_WIDTH'(16);

  localparam logic KIND_SIGN  = 1'b0;
  localparam logic KIND_DIGIT = 1'b1;

  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [RADIX_WIDTH-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [DIGIT_WIDTH-1:0] remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/signed_integer_to_radix_digits.sv */
// Top level: converts a signed value to digits in the configured radix.
// Depends on sird_pkg and sird_div_unit.
//
// Usage:
//   Input: present in_value with start; the item is taken at a clock edge with
//   start high and busy low. busy stays high until the last result is out.
//   Config: cfg_data (radix) is written when cfg_valid and cfg_ready are high;
//   cfg_ready is always high. Radix 0..1 acts as 2, 17..31 acts as 16.
//   Write it only while busy is low.
//   Results: one item per out_valid cycle; a minus-sign item first for a
//   negative value, then digits most significant first, out_last_item on the
//   final digit. The receiver cannot stall; results are never held.
// Sequence:
//   Each digit is computed in turn by the shared divider; all digits are
//   found before the first result item goes out. The most negative value
//   gives 32 binary digits. The next item can be taken in the cycle after
//   the last result.
// Reset: radix returns to 10, any item in flight is dropped, busy goes low.
`default_nettype none

module signed_integer_to_radix_digits
  import sird_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output      logic                   busy,
  input  wire logic [VALUE_WIDTH-1:0] in_value,
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [RADIX_WIDTH-1:0] cfg_data,
  output      logic                   out_valid,
  output      logic                   out_item_kind,
  output      logic [DIGIT_WIDTH-1:0] out_digit_value,
  output      logic                   out_last_item
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_SIGN = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [RADIX_WIDTH-1:0]           radix_r;
  logic [RADIX_WIDTH-1:0]           radix_eff;
  logic                             neg_r;
  logic [VALUE_WIDTH*DIGIT_WIDTH-1:0] stack_r;
  logic [NDIG_W-1:0]                ndig_r;
  logic [VALUE_WIDTH-1:0]           mag_in;
  logic                             accept;
  div_req_t                         req;
  div_rsp_t                         rsp;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;

  always_comb begin
    priority if (radix_r < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix_r;
    end
  end

  // two's complement negate; the most negative value maps to 2^(W-1)
  assign mag_in = in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;

  always_comb begin
    req.divisor  = radix_eff;
    req.dividend = (state_r == S_IDLE) ? mag_in : rsp.quotient;
    req.start    = accept ||
                   ((state_r == S_DIV) && rsp.done && (rsp.quotient != '0));
  end

  sird_div_unit u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (rsp.done && (rsp.quotient == '0)) state_nxt = neg_r ? S_SIGN : S_EMIT;
      end
      S_SIGN: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (ndig_r == NDIG_W'(1)) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      radix_r <= RADIX_RESET;
      ndig_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) radix_r <= cfg_data;
      if (accept) begin
        neg_r  <= in_value[VALUE_WIDTH-1];
        ndig_r <= '0;
      end else if ((state_r == S_DIV) && rsp.done) begin
        ndig_r <= ndig_r + 1'b1;
      end else if (state_r == S_EMIT) begin
        ndig_r <= ndig_r - 1'b1;
      end
    end
  end

  // digit stack: newest (most significant) digit sits in the low nibble
  always_ff @(posedge clk) begin
    if ((state_r == S_DIV) && rsp.done) begin
      stack_r <= {stack_r[VALUE_WIDTH*DIGIT_WIDTH-DIGIT_WIDTH-1:0], rsp.remainder};
    end else if (state_r == S_EMIT) begin
      stack_r <= stack_r >> DIGIT_WIDTH;
    end
  end

  assign out_valid       = (state_r == S_SIGN) || (state_r == S_EMIT);
  assign out_item_kind   = (state_r == S_EMIT) ? KIND_DIGIT : KIND_SIGN;
  assign out_digit_value = (state_r == S_EMIT) ? stack_r[DIGIT_WIDTH-1:0] : '0;
  assign out_last_item   = (state_r == S_EMIT) && (ndig_r == NDIG_W'(1));

  a_out_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_item |=> !busy)
    else $error("block still busy after last item");

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item_kind == KIND_SIGN) |-> !out_last_item)
    else $error("sign item marked last");

  a_digit_in_radix: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item_kind == KIND_DIGIT) |->
      ({1'b0, out_digit_value} < radix_eff))
    else $error("digit out of radix range");

  a_emit_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (ndig_r != '0))
    else $error("emitting with empty digit stack");

endmodule

`default_nettype wire

/* hw/rtl/sird_div_unit.sv */
// Iterative unsigned divider by a small radix, STEP_BITS quotient bits per cycle.
// Depends on sird_pkg.
`default_nettype none

module sird_div_unit
  import sird_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic [DIGIT_WIDTH-1:0] rem_r, rem_nxt;
  logic [RADIX_WIDTH-1:0] dvs_r;
  logic [STEP_CNT_W-1:0]  cnt_r;
  logic                   active_r;
  logic                   done_r;

  always_comb begin
    logic [DIGIT_WIDTH-1:0] r;
    logic [RADIX_WIDTH-1:0] t;
    logic [STEP_BITS-1:0]   q;
    r = rem_r;
    q = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      t = {r, acc_r[VALUE_WIDTH-1-i]};
      if (t >= dvs_r) begin
        t = t - dvs_r;
        q[STEP_BITS-1-i] = 1'b1;
      end
      r = t[DIGIT_WIDTH-1:0];
    end
    rem_nxt = r;
    acc_nxt = (acc_r << STEP_BITS) | VALUE_WIDTH'(q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (active_r) begin
        acc_r <= acc_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == STEP_CNT_W'(DIV_STEPS - 1)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end else if (req.start) begin
        acc_r    <= req.dividend;
        rem_r    <= '0;
        dvs_r    <= req.divisor;
        cnt_r    <= '0;
        active_r <= 1'b1;
      end
    end
  end

  assign rsp = '{done: done_r, quotient: acc_r, remainder: rem_r};

endmodule

`default_nettype wire
